>>> sv/dpc_pkg.sv
// shared types and constants for the dof predictor with clamp and running maxima
`timescale 1ns / 1ps

package dpc_pkg;

    // dofs per node limit and position counter width
    localparam int unsigned MAX_DOFS = 8;
    localparam int unsigned POS_W    = $clog2(MAX_DOFS);

    // queue depths
    localparam int unsigned WORK_DEPTH = 4;
    localparam int unsigned WORK_PTR_W = $clog2(WORK_DEPTH);
    localparam int unsigned OUT_DEPTH  = 8;
    localparam int unsigned OUT_PTR_W  = $clog2(OUT_DEPTH);

    // configuration register indexes
    localparam logic [2:0] CFG_TIME_STEP     = 3'd0;
    localparam logic [2:0] CFG_DYNAMIC       = 3'd1;
    localparam logic [2:0] CFG_THERMAL_MODE  = 3'd2;
    localparam logic [2:0] CFG_LATER_INCR    = 3'd3;
    localparam logic [2:0] CFG_DISCONTINUITY = 3'd4;
    localparam logic [2:0] CFG_DOFS_PER_NODE = 3'd5;

    // thermal mode codes, the unused code behaves as mechanical only
    localparam logic [1:0] MODE_MECHANICAL = 2'd0;
    localparam logic [1:0] MODE_THERMAL    = 2'd1;
    localparam logic [1:0] MODE_COUPLED    = 2'd2;

    // reset value of dofs per node
    localparam logic [3:0] DOFS_PER_NODE_RST = 4'd4;

    // thermal increment clamp (100.0 in q16.16) and peak ceiling
    localparam logic signed [47:0] THERM_LIMIT = 48'sd6553600;
    localparam logic [30:0]        PEAK_MAX    = 31'h7FFF_FFFF;

    // what the back end does with one dof
    typedef enum logic [1:0] {
        OP_COPY,
        OP_MECH,
        OP_THERM
    } t_dpc_op;

    // configuration registers
    typedef struct packed {
        logic [31:0] time_step;
        logic        dynamic_analysis;
        logic [1:0]  thermal_mode;
        logic        later_increment;
        logic        discontinuity;
        logic [3:0]  dofs_per_node;
    } t_dpc_cfg;

    // input request
    typedef struct packed {
        logic signed [31:0] old_value;
        logic signed [31:0] old_rate;
        logic               dof_active;
        logic               last_dof;
    } t_dpc_req;

    // result
    typedef struct packed {
        logic signed [31:0] new_value;
        logic [30:0]        max_mechanical;
        logic [30:0]        max_thermal;
        logic               final_res;
    } t_dpc_res;

    // classified request between front and back
    typedef struct packed {
        t_dpc_op            op;
        logic signed [31:0] old_value;
        logic signed [31:0] old_rate;
        logic               dof_active;
        logic               last_dof;
    } t_dpc_work;

endpackage

>>> sv/dpc_front.sv
// front end: accepts requests, tracks dof position, classifies and queues them
`timescale 1ns / 1ps

module dpc_front (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dpc_pkg::t_dpc_cfg   i_cfg,
    input  logic                push,
    output logic                full,
    input  dpc_pkg::t_dpc_req   i_req,
    output logic                o_work_valid,
    input  logic                i_work_ready,
    output dpc_pkg::t_dpc_work  o_work
);

    logic [dpc_pkg::POS_W-1:0]      r_dof_position, n_dof_position;
    dpc_pkg::t_dpc_work             r_queue [dpc_pkg::WORK_DEPTH];
    logic [dpc_pkg::WORK_PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [dpc_pkg::WORK_PTR_W:0]   r_count, n_count;
    logic                           w_accept, w_pop, w_extrap, w_temp;
    logic [3:0]                     w_dpn;
    logic [dpc_pkg::POS_W:0]        w_pos_inc;
    dpc_pkg::t_dpc_op               w_op;
    dpc_pkg::t_dpc_work             w_work;

    assign full         = (r_count == (dpc_pkg::WORK_PTR_W+1)'(dpc_pkg::WORK_DEPTH));
    assign w_accept     = push && !full;
    assign o_work_valid = (r_count != '0);
    assign w_pop        = o_work_valid && i_work_ready;
    assign o_work       = r_queue[r_rd_ptr];

    // effective dofs per node, zero reads as one and large values as the limit
    always_comb begin
        w_dpn = i_cfg.dofs_per_node;
        if (i_cfg.dofs_per_node == 4'd0) begin
            w_dpn = 4'd1;
        end else if (i_cfg.dofs_per_node > 4'(dpc_pkg::MAX_DOFS)) begin
            w_dpn = 4'(dpc_pkg::MAX_DOFS);
        end
    end

    // classify the request from mode and position
    assign w_temp   = (r_dof_position == '0);
    assign w_extrap = i_cfg.dynamic_analysis || (i_cfg.later_increment && !i_cfg.discontinuity);

    always_comb begin
        case (i_cfg.thermal_mode)
            dpc_pkg::MODE_THERMAL: w_op = w_temp ? dpc_pkg::OP_THERM : dpc_pkg::OP_COPY;
            dpc_pkg::MODE_COUPLED: w_op = w_temp ? dpc_pkg::OP_THERM : dpc_pkg::OP_MECH;
            default:               w_op = dpc_pkg::OP_MECH;
        endcase
        if (!w_extrap) begin
            w_op = dpc_pkg::OP_COPY;
        end
    end

    always_comb begin
        w_work.op         = w_op;
        w_work.old_value  = i_req.old_value;
        w_work.old_rate   = i_req.old_rate;
        w_work.dof_active = i_req.dof_active;
        w_work.last_dof   = i_req.last_dof;
    end

    // next dof position
    assign w_pos_inc = {1'b0, r_dof_position} + (dpc_pkg::POS_W+1)'(1);

    always_comb begin
        n_dof_position = r_dof_position;
        if (w_accept) begin
            if (i_req.last_dof || (4'(w_pos_inc) >= w_dpn)) begin
                n_dof_position = '0;
            end else begin
                n_dof_position = w_pos_inc[dpc_pkg::POS_W-1:0];
            end
        end
    end

    // queue occupancy
    always_comb begin
        n_count = r_count;
        if (w_accept && !w_pop) begin
            n_count = r_count + (dpc_pkg::WORK_PTR_W+1)'(1);
        end else if (!w_accept && w_pop) begin
            n_count = r_count - (dpc_pkg::WORK_PTR_W+1)'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dof_position <= '0;
            r_count        <= '0;
            r_wr_ptr       <= '0;
            r_rd_ptr       <= '0;
        end else begin
            r_dof_position <= n_dof_position;
            r_count        <= n_count;
            if (w_accept) begin
                r_wr_ptr <= r_wr_ptr + dpc_pkg::WORK_PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + dpc_pkg::WORK_PTR_W'(1);
            end
        end
    end

    // queue storage
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_queue[r_wr_ptr] <= w_work;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= (dpc_pkg::WORK_PTR_W+1)'(dpc_pkg::WORK_DEPTH))
        else $error("work queue count out of range");

    a_last_clears_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && i_req.last_dof) |=> (r_dof_position == '0))
        else $error("position not cleared after last dof");

    a_head_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_work_valid && !i_work_ready) |=> (o_work_valid && $stable(o_work)))
        else $error("queue head changed while stalled");

endmodule

>>> sv/dpc_back.sv
// back end: multiply pipeline, clamp and saturation, running peaks, result queue
`timescale 1ns / 1ps

module dpc_back (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic [31:0]         i_time_step,
    input  logic                i_work_valid,
    output logic                o_work_ready,
    input  dpc_pkg::t_dpc_work  i_work,
    output logic                empty,
    input  logic                pop,
    output dpc_pkg::t_dpc_res   o_res
);

    localparam logic signed [48:0] SUM_MAX = 49'sh0_7FFF_FFFF;
    localparam logic signed [48:0] SUM_MIN = -49'sh0_8000_0000;

    // stage 1: product
    logic                       r_s1_valid;
    logic signed [63:0]         r_s1_prod;
    dpc_pkg::t_dpc_op           r_s1_op;
    logic signed [31:0]         r_s1_old;
    logic                       r_s1_active, r_s1_last;
    // stage 2: increment, magnitude, sum
    logic                       r_s2_valid;
    logic signed [31:0]         r_s2_newv;
    logic [30:0]                r_s2_mag;
    dpc_pkg::t_dpc_op           r_s2_op;
    logic                       r_s2_active, r_s2_last;
    // peaks
    logic [30:0]                r_mech_peak, n_mech_peak;
    logic [30:0]                r_therm_peak, n_therm_peak;
    // result queue
    dpc_pkg::t_dpc_res          r_out [dpc_pkg::OUT_DEPTH];
    logic [dpc_pkg::OUT_PTR_W-1:0] r_out_wr, r_out_rd;
    logic [dpc_pkg::OUT_PTR_W:0]   r_out_count, n_out_count;

    logic                       w_take, w_out_pop;
    logic [dpc_pkg::OUT_PTR_W+1:0] w_reserved;
    logic signed [32:0]         w_ts;
    logic signed [64:0]         w_prod;
    logic signed [47:0]         w_d;
    logic signed [48:0]         w_d_ext, w_mag_full, w_sum;
    logic [30:0]                w_mag;
    logic signed [31:0]         w_newv;
    logic [30:0]                w_mech_upd, w_therm_upd;
    dpc_pkg::t_dpc_res          w_res;

    // take a request only when the result queue has room for everything in flight
    assign w_reserved   = (dpc_pkg::OUT_PTR_W+2)'(r_out_count)
                        + (dpc_pkg::OUT_PTR_W+2)'(r_s1_valid)
                        + (dpc_pkg::OUT_PTR_W+2)'(r_s2_valid);
    assign o_work_ready = (w_reserved < (dpc_pkg::OUT_PTR_W+2)'(dpc_pkg::OUT_DEPTH));
    assign w_take       = i_work_valid && o_work_ready;

    // time step times rate, full precision
    assign w_ts   = $signed({1'b0, i_time_step});
    assign w_prod = w_ts * i_work.old_rate;

    // floor shift, optional thermal clamp
    always_comb begin
        w_d = r_s1_prod[63:16];
        if (r_s1_op == dpc_pkg::OP_THERM) begin
            if (w_d > dpc_pkg::THERM_LIMIT) begin
                w_d = dpc_pkg::THERM_LIMIT;
            end else if (w_d < -dpc_pkg::THERM_LIMIT) begin
                w_d = -dpc_pkg::THERM_LIMIT;
            end
        end
    end

    // saturated magnitude and saturated sum
    assign w_d_ext    = {w_d[47], w_d};
    assign w_mag_full = w_d[47] ? -w_d_ext : w_d_ext;
    assign w_mag      = (w_mag_full > $signed({18'd0, dpc_pkg::PEAK_MAX}))
                      ? dpc_pkg::PEAK_MAX : w_mag_full[30:0];
    assign w_sum      = {{17{r_s1_old[31]}}, r_s1_old} + w_d_ext;

    always_comb begin
        if (r_s1_op == dpc_pkg::OP_COPY) begin
            w_newv = r_s1_old;
        end else if (w_sum > SUM_MAX) begin
            w_newv = 32'sh7FFF_FFFF;
        end else if (w_sum < SUM_MIN) begin
            w_newv = -32'sh8000_0000;
        end else begin
            w_newv = w_sum[31:0];
        end
    end

    // peak update at commit
    always_comb begin
        w_mech_upd  = r_mech_peak;
        w_therm_upd = r_therm_peak;
        if (r_s2_active) begin
            if (r_s2_op == dpc_pkg::OP_MECH && r_s2_mag > r_mech_peak) begin
                w_mech_upd = r_s2_mag;
            end
            if (r_s2_op == dpc_pkg::OP_THERM && r_s2_mag > r_therm_peak) begin
                w_therm_upd = r_s2_mag;
            end
        end
    end

    always_comb begin
        n_mech_peak  = r_mech_peak;
        n_therm_peak = r_therm_peak;
        if (r_s2_valid) begin
            n_mech_peak  = r_s2_last ? '0 : w_mech_upd;
            n_therm_peak = r_s2_last ? '0 : w_therm_upd;
        end
    end

    always_comb begin
        w_res.new_value      = r_s2_newv;
        w_res.max_mechanical = w_mech_upd;
        w_res.max_thermal    = w_therm_upd;
        w_res.final_res      = r_s2_last;
    end

    // result queue occupancy
    assign empty     = (r_out_count == '0);
    assign w_out_pop = pop && !empty;
    assign o_res     = r_out[r_out_rd];

    always_comb begin
        n_out_count = r_out_count;
        if (r_s2_valid && !w_out_pop) begin
            n_out_count = r_out_count + (dpc_pkg::OUT_PTR_W+1)'(1);
        end else if (!r_s2_valid && w_out_pop) begin
            n_out_count = r_out_count - (dpc_pkg::OUT_PTR_W+1)'(1);
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid   <= 1'b0;
            r_s2_valid   <= 1'b0;
            r_mech_peak  <= '0;
            r_therm_peak <= '0;
            r_out_count  <= '0;
            r_out_wr     <= '0;
            r_out_rd     <= '0;
        end else begin
            r_s1_valid   <= w_take;
            r_s2_valid   <= r_s1_valid;
            r_mech_peak  <= n_mech_peak;
            r_therm_peak <= n_therm_peak;
            r_out_count  <= n_out_count;
            if (r_s2_valid) begin
                r_out_wr <= r_out_wr + dpc_pkg::OUT_PTR_W'(1);
            end
            if (w_out_pop) begin
                r_out_rd <= r_out_rd + dpc_pkg::OUT_PTR_W'(1);
            end
        end
    end

    // pipeline payload
    always_ff @(posedge i_clk) begin
        r_s1_prod   <= w_prod[63:0];
        r_s1_op     <= i_work.op;
        r_s1_old    <= i_work.old_value;
        r_s1_active <= i_work.dof_active;
        r_s1_last   <= i_work.last_dof;
        r_s2_newv   <= w_newv;
        r_s2_mag    <= w_mag;
        r_s2_op     <= r_s1_op;
        r_s2_active <= r_s1_active;
        r_s2_last   <= r_s1_last;
    end

    // result storage
    always_ff @(posedge i_clk) begin
        if (r_s2_valid) begin
            r_out[r_out_wr] <= w_res;
        end
    end

    a_room_reserved: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_reserved <= (dpc_pkg::OUT_PTR_W+2)'(dpc_pkg::OUT_DEPTH))
        else $error("result queue overbooked");

    a_peaks_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && r_s2_last) |=> (r_mech_peak == '0 && r_therm_peak == '0))
        else $error("peaks not cleared after last dof");

    a_copy_keeps_peaks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s2_valid && !r_s2_last && r_s2_op == dpc_pkg::OP_COPY)
        |=> ($stable(r_mech_peak) && $stable(r_therm_peak)))
        else $error("copied dof changed a peak");

    a_pop_on_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (empty && !r_s2_valid) |=> empty)
        else $error("result appeared without a commit");

endmodule

>>> sv/dof_predictor_clamp_max.sv
// Top level: configuration registers, front end and back end of the dof predictor
// Path: work queue, stage 1, stage 2, result queue. Throughput: one request per
// cycle while the result queue has room, set by the single 33x32 multiplier
// stage; a four-entry work queue and an eight-entry result queue absorb stalls.
// Reset (synchronous, i_rst_n low): queues empty, dof position and peaks zero,
// registers at their defaults; the block takes requests in the next cycle.
`timescale 1ns / 1ps

module dof_predictor_clamp_max (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [2:0]        i_cfg_index,
    input  logic [31:0]       i_cfg_wdata,
    input  logic              push,
    output logic              full,
    input  dpc_pkg::t_dpc_req i_req,
    output logic              empty,
    input  logic              pop,
    output dpc_pkg::t_dpc_res o_res
);

    dpc_pkg::t_dpc_cfg  r_cfg;
    dpc_pkg::t_dpc_work w_work;
    logic               w_work_valid, w_work_ready;

    // configuration register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.time_step        <= '0;
            r_cfg.dynamic_analysis <= 1'b0;
            r_cfg.thermal_mode     <= dpc_pkg::MODE_MECHANICAL;
            r_cfg.later_increment  <= 1'b0;
            r_cfg.discontinuity    <= 1'b0;
            r_cfg.dofs_per_node    <= dpc_pkg::DOFS_PER_NODE_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                dpc_pkg::CFG_TIME_STEP:     r_cfg.time_step        <= i_cfg_wdata;
                dpc_pkg::CFG_DYNAMIC:       r_cfg.dynamic_analysis <= i_cfg_wdata[0];
                dpc_pkg::CFG_THERMAL_MODE:  r_cfg.thermal_mode     <= i_cfg_wdata[1:0];
                dpc_pkg::CFG_LATER_INCR:    r_cfg.later_increment  <= i_cfg_wdata[0];
                dpc_pkg::CFG_DISCONTINUITY: r_cfg.discontinuity    <= i_cfg_wdata[0];
                dpc_pkg::CFG_DOFS_PER_NODE: r_cfg.dofs_per_node    <= i_cfg_wdata[3:0];
                default: begin
                end
            endcase
        end
    end

    // request intake and classification
    dpc_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (r_cfg),
        .push         (push),
        .full         (full),
        .i_req        (i_req),
        .o_work_valid (w_work_valid),
        .i_work_ready (w_work_ready),
        .o_work       (w_work)
    );

    // arithmetic, peaks and result queue
    dpc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_time_step  (r_cfg.time_step),
        .i_work_valid (w_work_valid),
        .o_work_ready (w_work_ready),
        .i_work       (w_work),
        .empty        (empty),
        .pop          (pop),
        .o_res        (o_res)
    );

endmodule
